@@ design/mpsm_pkg.sv @@
// ----------------------------------------------------------------------------
// Morris-Pratt stream matcher package
// Sizes and request action codes shared by the matcher and its testbench.
// ----------------------------------------------------------------------------
package mpsm_pkg;

    localparam int PATTERN_MAX = 256;
    localparam int SYMBOL_BITS = 32;
    localparam int IN_SYM_BITS = 32;
    localparam int POS_BITS    = 32;
    localparam int IDX_BITS    = $clog2(PATTERN_MAX + 1);
    localparam int ADDR_BITS   = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

    typedef enum logic [1:0] {
        ACT_APPEND = 2'd0,
        ACT_TEXT   = 2'd1,
        ACT_CLEAR  = 2'd2
    } t_action;

endpackage

@@ design/morris_pratt_stream_matcher_top.sv @@
// ----------------------------------------------------------------------------
// Morris-Pratt stream matcher
// Appends pattern symbols with online failure-link construction and scans
// text symbols for full pattern occurrences, one request at a time.
// ----------------------------------------------------------------------------
// A clear request, an append to a full pattern, a text symbol against an empty
// pattern and the unused action code each finish in the idle state. An append
// that starts with no build cursor finishes in the evaluate state. Any other
// append or text symbol passes the evaluate and compare states, goes back to
// evaluate through the link state for every failure link followed, and straight
// back when a mismatch at the first pattern symbol falls back to the start; a
// text symbol that completes a match then passes S_TAIL and S_TAILW. Link walks
// are amortised, so a long stream averages at most about two compares per
// symbol. The pace is set by the single symbol comparator and the registered
// reads of the pattern and link memories. The block accepts no request while
// one is in progress, nor while a finished result waits in the output register;
// a request can be taken in the cycle that the waiting result leaves.
module morris_pratt_stream_matcher_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [1:0]                    i_action,
    input  logic [mpsm_pkg::IN_SYM_BITS-1:0] i_symbol,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_match_found,
    output logic [mpsm_pkg::POS_BITS-1:0] o_match_start,
    output logic                          o_pattern_full
);

    import mpsm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_CMP,
        S_LINK,
        S_TAIL,
        S_TAILW
    } t_state;

    t_state                 r_state, n_state;
    t_action                r_act, n_act;
    logic [SYMBOL_BITS-1:0] r_sym, n_sym;
    logic [IDX_BITS-1:0]    r_cur, n_cur;
    logic                   r_cur_neg, n_cur_neg;
    logic [IDX_BITS-1:0]    r_len, n_len;
    logic [IDX_BITS-1:0]    r_bcur, n_bcur;
    logic                   r_bcur_neg, n_bcur_neg;
    logic [IDX_BITS-1:0]    r_mcur, n_mcur;
    logic [POS_BITS-1:0]    r_pos, n_pos;
    logic                   r_o_valid, n_o_valid;
    logic                   r_found, n_found;
    logic [POS_BITS-1:0]    r_start, n_start;
    logic                   r_full, n_full;

    logic [SYMBOL_BITS-1:0] r_store [PATTERN_MAX];
    logic [IDX_BITS-1:0]    r_links [PATTERN_MAX];
    logic [SYMBOL_BITS-1:0] r_mem_sym;
    logic [IDX_BITS-1:0]    r_mem_link;

    logic                   w_in_acc;
    logic                   w_stop;
    logic                   w_finish;
    logic [IDX_BITS-1:0]    w_step;
    logic [IDX_BITS-1:0]    w_len_m1;
    logic [IDX_BITS-1:0]    w_cur_m1;
    logic [ADDR_BITS-1:0]   w_link_raddr;
    logic                   w_store_we;
    logic                   w_link_we;

    assign o_stall  = !((r_state == S_IDLE) && (!r_o_valid || !i_stall));
    assign w_in_acc = i_valid && !o_stall;

    assign w_stop   = r_cur_neg || (r_cur >= r_len);
    assign w_step   = w_stop ? '0 : r_cur + IDX_BITS'(1);
    assign w_len_m1 = r_len - IDX_BITS'(1);
    assign w_cur_m1 = r_cur - IDX_BITS'(1);
    assign w_link_raddr = (r_state == S_TAIL) ? w_len_m1[ADDR_BITS-1:0]
                                              : w_cur_m1[ADDR_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (w_store_we) begin
            r_store[r_len[ADDR_BITS-1:0]] <= i_symbol[SYMBOL_BITS-1:0];
        end
        r_mem_sym <= r_store[r_cur[ADDR_BITS-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (w_link_we) begin
            r_links[r_len[ADDR_BITS-1:0]] <= w_step;
        end
        r_mem_link <= r_links[w_link_raddr];
    end

    always_comb begin
        n_state    = r_state;
        n_act      = r_act;
        n_sym      = r_sym;
        n_cur      = r_cur;
        n_cur_neg  = r_cur_neg;
        n_len      = r_len;
        n_bcur     = r_bcur;
        n_bcur_neg = r_bcur_neg;
        n_mcur     = r_mcur;
        n_pos      = r_pos;
        n_o_valid  = r_o_valid && i_stall;
        n_found    = r_found;
        n_start    = r_start;
        n_full     = r_full;
        w_store_we = 1'b0;
        w_link_we  = 1'b0;
        w_finish   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_act   = t_action'(i_action);
                    n_sym   = i_symbol[SYMBOL_BITS-1:0];
                    n_found = 1'b0;
                    n_start = '0;
                    n_full  = 1'b0;
                    unique case (i_action)
                        ACT_APPEND: begin
                            if (r_len == IDX_BITS'(PATTERN_MAX)) begin
                                n_full    = 1'b1;
                                n_o_valid = 1'b1;
                            end else begin
                                w_store_we = 1'b1;
                                n_cur      = r_bcur;
                                n_cur_neg  = r_bcur_neg;
                                n_state    = S_EVAL;
                            end
                        end
                        ACT_TEXT: begin
                            if (r_len == '0) begin
                                n_pos     = r_pos + POS_BITS'(1);
                                n_o_valid = 1'b1;
                            end else begin
                                n_cur     = r_mcur;
                                n_cur_neg = 1'b0;
                                n_state   = S_EVAL;
                            end
                        end
                        ACT_CLEAR: begin
                            n_len      = '0;
                            n_bcur     = '0;
                            n_bcur_neg = 1'b1;
                            n_mcur     = '0;
                            n_pos      = '0;
                            n_o_valid  = 1'b1;
                        end
                        default: begin
                            n_o_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_EVAL: begin
                if (w_stop) begin
                    w_finish = 1'b1;
                end else begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (r_mem_sym == r_sym) begin
                    w_finish = 1'b1;
                end else if (r_cur == '0) begin
                    n_cur_neg = 1'b1;
                    n_state   = S_EVAL;
                end else begin
                    n_state = S_LINK;
                end
            end
            S_LINK: begin
                n_cur   = r_mem_link;
                n_state = S_EVAL;
            end
            S_TAIL: begin
                n_state = S_TAILW;
            end
            S_TAILW: begin
                n_mcur    = r_mem_link;
                n_pos     = r_pos + POS_BITS'(1);
                n_o_valid = 1'b1;
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (w_finish) begin
            if (r_act == ACT_APPEND) begin
                w_link_we  = 1'b1;
                n_bcur     = w_step;
                n_bcur_neg = 1'b0;
                n_len      = r_len + IDX_BITS'(1);
                n_mcur     = '0;
                n_pos      = '0;
                n_o_valid  = 1'b1;
                n_state    = S_IDLE;
            end else if (w_step == r_len) begin
                n_found = 1'b1;
                n_start = r_pos - POS_BITS'(w_len_m1);
                n_state = S_TAIL;
            end else begin
                n_mcur    = w_step;
                n_pos     = r_pos + POS_BITS'(1);
                n_o_valid = 1'b1;
                n_state   = S_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_len      <= '0;
            r_bcur     <= '0;
            r_bcur_neg <= 1'b1;
            r_mcur     <= '0;
            r_pos      <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_len      <= n_len;
            r_bcur     <= n_bcur;
            r_bcur_neg <= n_bcur_neg;
            r_mcur     <= n_mcur;
            r_pos      <= n_pos;
            r_o_valid  <= n_o_valid;
        end
        r_act     <= n_act;
        r_sym     <= n_sym;
        r_cur     <= n_cur;
        r_cur_neg <= n_cur_neg;
        r_found   <= n_found;
        r_start   <= n_start;
        r_full    <= n_full;
    end

    assign o_valid        = r_o_valid;
    assign o_match_found  = r_found;
    assign o_match_start  = r_start;
    assign o_pattern_full = r_full;

    a_busy_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !r_o_valid)
        else $error("result pending while a request is in progress");

    a_cmp_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> (!r_cur_neg && (r_cur < r_len)))
        else $error("compare issued outside the stored pattern");

    a_build_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_bcur_neg |-> (r_bcur < r_len))
        else $error("build cursor beyond pattern length");

    a_match_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_len == '0) || (r_mcur < r_len))
        else $error("match cursor beyond pattern length");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= IDX_BITS'(PATTERN_MAX))
        else $error("pattern length beyond capacity");

endmodule

@@ verif/morris_pratt_stream_matcher_top_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Morris-Pratt stream matcher testbench
// Drives a table of directed requests and then random pattern and text
// sequences with random idling on both sides. An in-bench model of the matcher
// predicts each result that the directed table does not give, and each result is checked field by field.
// ----------------------------------------------------------------------------
module morris_pratt_stream_matcher_top_test;

    import mpsm_pkg::*;

    localparam logic [1:0] ACT_RESERVED = 2'd3;
    localparam int ITEM_TARGET = 1600;
    localparam int QUIET_TAIL  = 200;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 20;
    localparam int N_DIRECTED  = 24;

    typedef struct packed {
        logic        found;
        logic [31:0] start;
        logic        full;
    } t_match_result;

    typedef struct packed {
        logic [1:0]  act;
        logic [31:0] sym;
        logic        known;
        logic        found;
        logic [31:0] start;
        logic        full;
    } t_request_row;

    logic                i_clk;
    logic                i_rst_n  = 1'b0;
    logic                i_valid  = 1'b0;
    logic                o_stall;
    logic [1:0]          i_action = ACT_CLEAR;
    logic [IN_SYM_BITS-1:0] i_symbol = '0;
    logic                o_valid;
    logic                i_stall  = 1'b0;
    logic                o_match_found;
    logic [POS_BITS-1:0] o_match_start;
    logic                o_pattern_full;

    // Model state of the matcher.
    logic [31:0] pat_sym [PATTERN_MAX];
    int          fail_link [PATTERN_MAX + 1];
    int          pat_len   = 0;
    int          build_pos = -1;
    int          scan_pos  = 0;
    logic [31:0] text_pos  = '0;

    t_match_result pending_matches [$];
    int            mismatch_count = 0;
    int            requests_done  = 0;
    int            cycle_count    = 0;
    int            stall_left     = 0;
    bit            steady         = 1'b0;

    morris_pratt_stream_matcher_top u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_action       (i_action),
        .i_symbol       (i_symbol),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_match_found  (o_match_found),
        .o_match_start  (o_match_start),
        .o_pattern_full (o_pattern_full)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        foreach (pat_sym[i]) pat_sym[i] = '0;
        foreach (fail_link[i]) fail_link[i] = 0;
        fail_link[0] = -1;
    end

    function automatic t_match_result advance_matcher(input logic [1:0] act,
                                                      input logic [31:0] sym);
        t_match_result res;
        int k;
        int c;
        res = '0;
        case (act)
            ACT_APPEND: begin
                if (pat_len >= PATTERN_MAX) begin
                    res.full = 1'b1;
                end else begin
                    k = pat_len;
                    c = build_pos;
                    pat_sym[k] = sym;
                    while (c >= 0 && c < k && pat_sym[c] != sym) c = fail_link[c];
                    if (c >= k) c = -1;
                    c = c + 1;
                    fail_link[k + 1] = c;
                    build_pos = c;
                    pat_len = k + 1;
                    scan_pos = 0;
                    text_pos = '0;
                end
            end
            ACT_TEXT: begin
                if (pat_len > 0) begin
                    c = scan_pos;
                    while (c >= 0 && c < pat_len && pat_sym[c] != sym) c = fail_link[c];
                    if (c >= pat_len) c = -1;
                    c = c + 1;
                    if (c == pat_len) begin
                        res.found = 1'b1;
                        res.start = text_pos - 32'(pat_len - 1);
                        c = fail_link[pat_len];
                    end
                    scan_pos = c;
                end
                text_pos = text_pos + 32'd1;
            end
            ACT_CLEAR: begin
                pat_len = 0;
                build_pos = -1;
                fail_link[0] = -1;
                scan_pos = 0;
                text_pos = '0;
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    task automatic send_request(input logic [1:0] act, input logic [31:0] sym,
                                input bit use_typed, input t_match_result typed);
        int gap;
        t_match_result res;
        gap = 0;
        if (!steady && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 6);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_action <= act;
        i_symbol <= sym;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        res = advance_matcher(act, sym);
        pending_matches.insert(pending_matches.size(), use_typed ? typed : res);
        if (act != ACT_RESERVED) requests_done++;
    endtask

    task automatic send_symbol(input logic [1:0] act, input logic [31:0] sym);
        send_request(act, sym, 1'b0, '0);
    endtask

    task automatic hold_until_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_matches.size() != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (stall_left == 0 && !steady && $urandom_range(0, 7) == 0)
            stall_left = $urandom_range(1, 6);
        if (stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left--;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin : result_check
        t_match_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_matches.size() == 0) begin
                $display("%0t: result with none expected, found %0b start %0h full %0b",
                         $time, o_match_found, o_match_start, o_pattern_full);
                mismatch_count++;
            end else begin
                want = pending_matches.pop_front();
                if (o_match_found !== want.found) begin
                    $display("%0t: match_found expected %0b actual %0b",
                             $time, want.found, o_match_found);
                    mismatch_count++;
                end
                if (o_match_start !== want.start) begin
                    $display("%0t: match_start expected %0h actual %0h",
                             $time, want.start, o_match_start);
                    mismatch_count++;
                end
                if (o_pattern_full !== want.full) begin
                    $display("%0t: pattern_full expected %0b actual %0b",
                             $time, want.full, o_pattern_full);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin : stimulus
        t_request_row  directed_rows [N_DIRECTED];
        t_match_result typed;
        logic [31:0]   alphabet [3];
        logic [31:0]   pat_copy [64];
        logic [31:0]   sym;
        int            seq_no;
        int            kind;
        int            n_alpha;
        int            plen;
        int            tlen;
        int            pos;
        int            fill_len;

        directed_rows = '{
            '{ACT_TEXT,     32'h0000_0000, 1'b1, 1'b0, 32'd0, 1'b0},
            '{ACT_RESERVED, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'd0, 1'b0},
            '{ACT_APPEND,   32'hFFFF_FFFF, 1'b1, 1'b0, 32'd0, 1'b0},
            '{ACT_TEXT,     32'hFFFF_FFFF, 1'b1, 1'b1, 32'd0, 1'b0},
            '{ACT_TEXT,     32'hFFFF_FFFF, 1'b1, 1'b1, 32'd1, 1'b0},
            '{ACT_TEXT,     32'h0000_0000, 1'b1, 1'b0, 32'd0, 1'b0},
            '{ACT_APPEND,   32'h0000_0000, 1'b1, 1'b0, 32'd0, 1'b0},
            '{ACT_TEXT,     32'hFFFF_FFFF, 1'b1, 1'b0, 32'd0, 1'b0},
            '{ACT_TEXT,     32'h0000_0000, 1'b1, 1'b1, 32'd0, 1'b0},
            '{ACT_CLEAR,    32'hFFFF_FFFF, 1'b1, 1'b0, 32'd0, 1'b0},
            '{ACT_TEXT,     32'hFFFF_FFFF, 1'b1, 1'b0, 32'd0, 1'b0},
            '{ACT_APPEND,   32'hA5A5_A5A5, 1'b1, 1'b0, 32'd0, 1'b0},
            '{ACT_APPEND,   32'hA5A5_A5A5, 1'b1, 1'b0, 32'd0, 1'b0},
            '{ACT_APPEND,   32'h5A5A_5A5A, 1'b1, 1'b0, 32'd0, 1'b0},
            '{ACT_TEXT,     32'hA5A5_A5A5, 1'b0, 1'b0, 32'd0, 1'b0},
            '{ACT_TEXT,     32'hA5A5_A5A5, 1'b0, 1'b0, 32'd0, 1'b0},
            '{ACT_TEXT,     32'hA5A5_A5A5, 1'b0, 1'b0, 32'd0, 1'b0},
            '{ACT_TEXT,     32'h5A5A_5A5A, 1'b0, 1'b0, 32'd0, 1'b0},
            '{ACT_TEXT,     32'hA5A5_A5A5, 1'b0, 1'b0, 32'd0, 1'b0},
            '{ACT_TEXT,     32'hA5A5_A5A5, 1'b0, 1'b0, 32'd0, 1'b0},
            '{ACT_TEXT,     32'h5A5A_5A5A, 1'b0, 1'b0, 32'd0, 1'b0},
            '{ACT_TEXT,     32'h1234_5678, 1'b0, 1'b0, 32'd0, 1'b0},
            '{ACT_CLEAR,    32'h0000_0000, 1'b1, 1'b0, 32'd0, 1'b0},
            '{ACT_RESERVED, 32'h0000_0000, 1'b1, 1'b0, 32'd0, 1'b0}
        };

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r]) begin
            typed = '{directed_rows[r].found, directed_rows[r].start, directed_rows[r].full};
            send_request(directed_rows[r].act, directed_rows[r].sym,
                         directed_rows[r].known, typed);
        end
        hold_until_drained();

        seq_no = 0;
        while (requests_done < ITEM_TARGET) begin
            steady = (requests_done >= ITEM_TARGET - QUIET_TAIL) || ($urandom_range(0, 5) == 0);
            if (seq_no > 0 && $urandom_range(0, 19) == 0) hold_until_drained();
            kind = (seq_no == 0) ? 0 : $urandom_range(2, 99);
            if (kind < 4) begin
                // Fill the pattern store and push a few appends past its end.
                alphabet[0] = $urandom;
                alphabet[1] = ~alphabet[0];
                send_symbol(ACT_CLEAR, $urandom);
                fill_len = PATTERN_MAX + $urandom_range(1, 3);
                for (int i = 0; i < fill_len; i++)
                    send_symbol(ACT_APPEND, alphabet[($urandom_range(0, 15) == 0) ? 1 : 0]);
                for (int i = 0; i < 40; i++)
                    send_symbol(ACT_TEXT, alphabet[($urandom_range(0, 15) == 0) ? 1 : 0]);
            end else if (kind < 12) begin
                for (int i = $urandom_range(1, 8); i > 0; i--)
                    send_symbol(2'($urandom_range(0, 3)), $urandom);
            end else begin
                n_alpha = $urandom_range(1, 3);
                for (int i = 0; i < 3; i++) alphabet[i] = $urandom;
                if ($urandom_range(0, 3) == 0)
                    alphabet[1] = alphabet[0] ^ (32'h1 << $urandom_range(0, 31));
                if ($urandom_range(0, 4) != 0) send_symbol(ACT_CLEAR, $urandom);
                plen = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40)
                                                   : $urandom_range(1, 6);
                for (int i = 0; i < plen; i++) begin
                    pat_copy[i] = alphabet[$urandom_range(0, n_alpha - 1)];
                    send_symbol(ACT_APPEND, pat_copy[i]);
                end
                tlen = $urandom_range(4, 30);
                pos = 0;
                while (pos < tlen) begin
                    if (kind < 20 && $urandom_range(0, 5) == 0) begin
                        // A broken sequence: stray symbol or mid-text append.
                        if ($urandom_range(0, 1) == 0) send_symbol(ACT_TEXT, $urandom);
                        else send_symbol(ACT_APPEND, alphabet[$urandom_range(0, n_alpha - 1)]);
                        pos++;
                    end else if ($urandom_range(0, 3) == 0) begin
                        for (int i = 0; i < plen; i++) send_symbol(ACT_TEXT, pat_copy[i]);
                        pos += plen;
                    end else begin
                        sym = alphabet[$urandom_range(0, n_alpha - 1)];
                        send_symbol(ACT_TEXT, sym);
                        pos++;
                    end
                end
            end
            seq_no++;
        end
        i_valid <= 1'b0;
        steady = 1'b1;

        while (pending_matches.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatch_count == 0 && pending_matches.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
